### hdl/tanh_soft_limiter_with_meter_core_assert.svh
// assertion macros shared by the soft limiter rtl
// no dependencies; each use expands to one labeled concurrent assertion
`ifndef TANH_SOFT_LIMITER_WITH_METER_CORE_ASSERT_SVH
`define TANH_SOFT_LIMITER_WITH_METER_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define TSLM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define TSLM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/tslm_pkg.sv
// shared constants and elaboration-time table functions for the soft limiter
// no dependencies; imported by every module of the block
package tslm_pkg;

    // defaults for the top-level parameters
    localparam int TANH_ENTRIES_DEF = 64;
    localparam int CLIP_BITS_DEF    = 32;

    // field widths and fixed levels
    localparam int          SAMPLE_BITS = 16;
    localparam int          CLIP_OUT_BITS = 32;
    localparam logic [15:0] VOL_RESET   = 16'd16384;
    localparam logic [15:0] VOL_UNITY   = 16'd32768;
    localparam logic [15:0] CLIP_LEVEL  = 16'd32767;

    // fixed-point layout: table in Q24, scaled magnitude argument in Q30
    localparam int ROM_BITS   = 24;
    localparam int FRAC_BITS  = 30;
    localparam int OUT_SHIFT  = 10;
    localparam int LIM_BITS   = ROM_BITS - OUT_SHIFT;
    localparam int DIGIT_BITS = 2;
    localparam int Q28_SHIFT  = 28;

    // unsigned quotient by shift and subtract, used only for the table build
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        int          b;
        q   = '0;
        rem = '0;
        for (b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^x in Q28 by truncated taylor terms, x given in Q28
    function automatic logic [63:0] exp_small_q28(input logic [63:0] dq);
        logic [63:0] sum;
        logic [63:0] term;
        int          n;
        sum  = 64'd1 << Q28_SHIFT;
        term = 64'd1 << Q28_SHIFT;
        for (n = 1; n < 40; n++) begin
            if (term != 64'd0) begin
                term = udiv64(term * dq, 64'(n) << Q28_SHIFT);
                sum  = sum + term;
            end
        end
        return sum;
    endfunction

    // table entry k: tanh from the k-th power of the step exponential, Q24
    function automatic logic [ROM_BITS-1:0] tanh_entry(input int k, input logic [63:0] e_q28);
        logic [63:0] one;
        logic [63:0] p;
        logic [63:0] num;
        int          j;
        one = 64'd1 << Q28_SHIFT;
        p   = one;
        for (j = 1; j <= k; j++) begin
            p = (p * e_q28 + (one >> 1)) >> Q28_SHIFT;
        end
        num = (p - one) << ROM_BITS;
        return ROM_BITS'(udiv64(num, p + one));
    endfunction

endpackage

### hdl/tslm_meter.sv
// input meter: running peak of the sample magnitude and a saturating full-scale count
// depends on tslm_pkg and the assertion macro header
`include "tanh_soft_limiter_with_meter_core_assert.svh"

module tslm_meter
    import tslm_pkg::*;
#(
    parameter int CLIP_COUNT_BITS = CLIP_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_upd,
    input  logic [SAMPLE_BITS-1:0]   i_mag,
    input  logic                     i_restart,
    output logic [SAMPLE_BITS-1:0]   o_peak,
    output logic [CLIP_OUT_BITS-1:0] o_clip_total
);

    logic [SAMPLE_BITS-1:0]     r_peak;
    logic [SAMPLE_BITS-1:0]     n_peak;
    logic [CLIP_COUNT_BITS-1:0] r_clip;
    logic [CLIP_COUNT_BITS-1:0] n_clip;
    logic [SAMPLE_BITS-1:0]     w_base;

    // peak restart happens before this word is metered
    always_comb begin
        w_base = i_restart ? '0 : r_peak;
        n_peak = (i_mag > w_base) ? i_mag : w_base;
        n_clip = r_clip;
        if ((i_mag >= CLIP_LEVEL) && !(&r_clip)) begin
            n_clip = r_clip + 1'b1;
        end
    end

    // meter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
            r_clip <= '0;
        end else if (i_upd) begin
            r_peak <= n_peak;
            r_clip <= n_clip;
        end
    end

    assign o_peak = r_peak;

    // report the count saturated to the output width
    generate
        if (CLIP_COUNT_BITS > CLIP_OUT_BITS) begin : g_clip_sat
            assign o_clip_total = (|r_clip[CLIP_COUNT_BITS-1:CLIP_OUT_BITS]) ?
                                  '1 : r_clip[CLIP_OUT_BITS-1:0];
        end else begin : g_clip_ext
            assign o_clip_total = CLIP_OUT_BITS'(r_clip);
        end
    endgenerate

    // the peak after an update always covers the word just metered
    `TSLM_ASSERT_NEXT(a_peak_covers, i_clk, i_rst_n, i_upd, r_peak >= $past(i_mag), "peak below metered magnitude")
    // the full-scale count never wraps
    `TSLM_ASSERT_NEXT(a_clip_no_wrap, i_clk, i_rst_n, i_upd, r_clip >= $past(r_clip), "clip count wrapped")

endmodule

### hdl/tslm_scale.sv
// serial scaler: magnitude times volume times table size, two multiplier bits a cycle
// depends on tslm_pkg
module tslm_scale
    import tslm_pkg::*;
#(
    parameter  int TANH_TABLE_ENTRIES = TANH_ENTRIES_DEF,
    localparam int S_BITS = FRAC_BITS + $clog2(TANH_TABLE_ENTRIES + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [SAMPLE_BITS-1:0] i_mag,
    input  logic [SAMPLE_BITS-1:0] i_vol,
    output logic                   o_done,
    output logic [S_BITS-1:0]      o_prod
);

    localparam int STEPS    = SAMPLE_BITS / DIGIT_BITS;
    localparam int CNT_BITS = $clog2(STEPS);

    logic                   r_busy;
    logic                   r_done;
    logic [CNT_BITS-1:0]    r_cnt;
    logic [SAMPLE_BITS-1:0] r_mag;
    logic [S_BITS-1:0]      r_mc;
    logic [S_BITS-1:0]      r_mc3;
    logic [S_BITS-1:0]      r_acc;
    logic [S_BITS-1:0]      w_addend;

    // partial product for the current magnitude digit
    always_comb begin
        unique case (r_mag[DIGIT_BITS-1:0])
            2'd0:    w_addend = '0;
            2'd1:    w_addend = r_mc;
            2'd2:    w_addend = r_mc << 1;
            default: w_addend = r_mc3;
        endcase
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift-add datapath; multiplicand is volume times table size, and its
    // triple may lose top bits late in the word only where the top magnitude
    // digit cannot be three
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= i_mag;
            r_mc  <= S_BITS'(i_vol) * S_BITS'(TANH_TABLE_ENTRIES);
            r_mc3 <= S_BITS'(i_vol) * S_BITS'(3 * TANH_TABLE_ENTRIES);
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + w_addend;
            r_mc  <= r_mc << DIGIT_BITS;
            r_mc3 <= r_mc3 << DIGIT_BITS;
            r_mag <= r_mag >> DIGIT_BITS;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

### hdl/tslm_interp.sv
// tanh table lookup and serial linear interpolation, two fraction bits a cycle
// depends on tslm_pkg and the assertion macro header
`include "tanh_soft_limiter_with_meter_core_assert.svh"

module tslm_interp
    import tslm_pkg::*;
#(
    parameter  int TANH_TABLE_ENTRIES = TANH_ENTRIES_DEF,
    localparam int S_BITS = FRAC_BITS + $clog2(TANH_TABLE_ENTRIES + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [S_BITS-1:0]   i_s,
    output logic                o_done,
    output logic [LIM_BITS-1:0] o_mag
);

    localparam int          I_BITS   = $clog2(TANH_TABLE_ENTRIES + 1);
    localparam int          F_STEPS  = FRAC_BITS / DIGIT_BITS;
    localparam int          CNT_BITS = $clog2(F_STEPS + 1);
    localparam int          D3_BITS  = ROM_BITS + 2;
    localparam logic [63:0] E_Q28    =
        exp_small_q28((64'd1 << FRAC_BITS) / 64'(TANH_TABLE_ENTRIES));

    logic [ROM_BITS-1:0]  w_rom [TANH_TABLE_ENTRIES+1];
    logic [I_BITS-1:0]    w_idx;
    logic                 w_top;
    logic [ROM_BITS-1:0]  w_lo;
    logic [ROM_BITS-1:0]  w_hi;
    logic [ROM_BITS-1:0]  w_d;
    logic [D3_BITS-1:0]   w_addend;
    logic [D3_BITS-1:0]   w_sum;

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [ROM_BITS-1:0]  r_lo;
    logic [ROM_BITS-1:0]  r_d;
    logic [D3_BITS-1:0]   r_d3;
    logic [FRAC_BITS-1:0] r_f;
    logic [ROM_BITS-1:0]  r_acc;
    logic [ROM_BITS-1:0]  r_y;

    // constant tanh table, built at elaboration
    generate
        for (genvar k = 0; k <= TANH_TABLE_ENTRIES; k++) begin : g_rom
            assign w_rom[k] = tanh_entry(k, E_Q28);
        end
    endgenerate

    // segment lookup; past the last segment the curve is flat at the end value
    always_comb begin
        w_idx = i_s[S_BITS-1:FRAC_BITS];
        w_top = (w_idx >= I_BITS'(TANH_TABLE_ENTRIES));
        if (w_top) begin
            w_lo = w_rom[TANH_TABLE_ENTRIES];
            w_hi = w_rom[TANH_TABLE_ENTRIES];
        end else begin
            w_lo = w_rom[w_idx];
            w_hi = w_rom[I_BITS'(w_idx + 1'b1)];
        end
        w_d = (w_hi > w_lo) ? (w_hi - w_lo) : '0;
    end

    // slope times fraction digit, accumulated and shifted right each step
    always_comb begin
        unique case (r_f[DIGIT_BITS-1:0])
            2'd0:    w_addend = '0;
            2'd1:    w_addend = D3_BITS'(r_d);
            2'd2:    w_addend = D3_BITS'(r_d) << 1;
            default: w_addend = r_d3;
        endcase
        w_sum = D3_BITS'(r_acc) + w_addend;
    end

    // step counter, with an extra step after the fraction digits for the final add
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_BITS'(F_STEPS)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // interpolation datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_lo  <= w_lo;
            r_d   <= w_d;
            r_d3  <= D3_BITS'(w_d) + (D3_BITS'(w_d) << 1);
            r_f   <= i_s[FRAC_BITS-1:0];
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_cnt == CNT_BITS'(F_STEPS)) begin
                r_y <= r_lo + r_acc;
            end else begin
                r_acc <= ROM_BITS'(w_sum >> DIGIT_BITS);
                r_f   <= r_f >> DIGIT_BITS;
            end
        end
    end

    assign o_done = r_done;
    assign o_mag  = r_y[ROM_BITS-1:OUT_SHIFT];

    // the interpolated step never exceeds the segment rise
    `TSLM_ASSERT_SAME(a_acc_in_segment, i_clk, i_rst_n, r_busy, r_acc <= r_d, "interpolation past segment end")

endmodule

### hdl/tanh_soft_limiter_with_meter_core.sv
// Soft limiter core: each accepted sample is scaled by the master volume and
// passed through 16384*tanh(x/16384) (table of TANH_TABLE_ENTRIES segments,
// linear interpolation, truncated toward zero); the raw input is metered for
// peak magnitude and full-scale count. One sample is in work at a time. A
// sample passes the serial volume scaler (two multiplier bits a cycle), the
// serial interpolator (15 two-bit fraction steps plus the final add) and the
// output register. The next sample is taken as soon as the result sits in the
// output register, even if the downstream side has not yet taken it. The user
// must write volume through i_cfg_we/i_cfg_data only while no sample is in
// work; the block itself does not enforce it.
`include "tanh_soft_limiter_with_meter_core_assert.svh"

module tanh_soft_limiter_with_meter_core
    import tslm_pkg::*;
#(
    parameter int TANH_TABLE_ENTRIES = TANH_ENTRIES_DEF,
    parameter int CLIP_COUNT_BITS    = CLIP_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [SAMPLE_BITS-1:0]          i_cfg_data,
    // input words
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [SAMPLE_BITS-1:0]   i_sample,
    input  logic                            i_last_in_block,
    input  logic                            i_peak_restart,
    // output words
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [SAMPLE_BITS-1:0]   o_limited_sample,
    output logic                            o_last_out,
    output logic [SAMPLE_BITS-1:0]          o_peak_level,
    output logic [CLIP_OUT_BITS-1:0]        o_clip_total
);

    localparam int S_BITS = FRAC_BITS + $clog2(TANH_TABLE_ENTRIES + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCALE  = 4'b0010,
        S_INTERP = 4'b0100,
        S_HOLD   = 4'b1000
    } t_state;

    t_state                   r_state;
    t_state                   n_state;
    logic [SAMPLE_BITS-1:0]   r_volume;
    logic                     r_neg;
    logic                     r_last;
    logic                     r_o_valid;
    logic [SAMPLE_BITS-1:0]   r_o_sample;
    logic                     r_o_last;
    logic [SAMPLE_BITS-1:0]   r_o_peak;
    logic [CLIP_OUT_BITS-1:0] r_o_clip;

    logic                     w_accept;
    logic                     w_out_free;
    logic                     w_load;
    logic [SAMPLE_BITS-1:0]   w_mag;
    logic [SAMPLE_BITS-1:0]   w_vol;
    logic                     w_scale_done;
    logic [S_BITS-1:0]        w_prod;
    logic                     w_interp_done;
    logic [LIM_BITS-1:0]      w_lim;
    logic [SAMPLE_BITS-1:0]   w_peak;
    logic [CLIP_OUT_BITS-1:0] w_clip;

    // handshake and sample magnitude
    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_o_valid || i_ready;
    assign w_mag      = i_sample[SAMPLE_BITS-1] ?
                        SAMPLE_BITS'(16'd0 - SAMPLE_BITS'(i_sample)) :
                        SAMPLE_BITS'(i_sample);
    assign w_vol      = (r_volume > VOL_UNITY) ? VOL_UNITY : r_volume;
    assign w_load     = ((r_state == S_INTERP) && w_interp_done || (r_state == S_HOLD))
                        && w_out_free;

    // volume register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume <= VOL_RESET;
        end else if (i_cfg_we) begin
            r_volume <= i_cfg_data;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_SCALE;
            end
            S_SCALE: begin
                if (w_scale_done) n_state = S_INTERP;
            end
            S_INTERP: begin
                if (w_interp_done) n_state = w_out_free ? S_IDLE : S_HOLD;
            end
            S_HOLD: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // per-word side information and output register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg  <= i_sample[SAMPLE_BITS-1];
            r_last <= i_last_in_block;
        end
        if (w_load) begin
            r_o_sample <= r_neg ? SAMPLE_BITS'(16'd0 - SAMPLE_BITS'(w_lim)) :
                                  SAMPLE_BITS'(w_lim);
            r_o_last   <= r_last;
            r_o_peak   <= w_peak;
            r_o_clip   <= w_clip;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_limited_sample = r_o_sample;
    assign o_last_out       = r_o_last;
    assign o_peak_level     = r_o_peak;
    assign o_clip_total     = r_o_clip;

    // meter on the raw input
    tslm_meter #(
        .CLIP_COUNT_BITS(CLIP_COUNT_BITS)
    ) u_meter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_upd       (w_accept),
        .i_mag       (w_mag),
        .i_restart   (i_peak_restart),
        .o_peak      (w_peak),
        .o_clip_total(w_clip)
    );

    // volume scaling into table coordinates
    tslm_scale #(
        .TANH_TABLE_ENTRIES(TANH_TABLE_ENTRIES)
    ) u_scale (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_accept),
        .i_mag  (w_mag),
        .i_vol  (w_vol),
        .o_done (w_scale_done),
        .o_prod (w_prod)
    );

    // tanh lookup and interpolation
    tslm_interp #(
        .TANH_TABLE_ENTRIES(TANH_TABLE_ENTRIES)
    ) u_interp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_scale_done),
        .i_s    (w_prod),
        .o_done (w_interp_done),
        .o_mag  (w_lim)
    );

    // an accepted word always starts the scaler
    `TSLM_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, w_accept, r_state == S_SCALE, "accepted word did not start scaling")
    // limited output stays within the tanh ceiling
    `TSLM_ASSERT_SAME(a_out_range, i_clk, i_rst_n, o_valid, ($signed(o_limited_sample) <= 16384) && ($signed(o_limited_sample) >= -16384), "limited sample out of range")

endmodule
